>>> rtl/pbta_pkg.sv
// Shared types, constants and helpers for the port table and dock allocator.
package pbta_pkg;

  localparam int TABLE_ENTRIES_DEF = 256;
  localparam int DOCK_COUNT_DEF    = 1024;

  localparam logic [15:0] DATA_AREA      = 16'h4000;
  localparam logic [15:0] DIR_SOURCE_BIT = 16'h0800;
  localparam logic [15:0] DIR_SINK_BIT   = 16'h0400;
  localparam logic [15:0] VALID_PAGE_BIT = 16'h0040;
  localparam logic [15:0] STATUS_MASK    = 16'h003F;

  localparam logic [2:0] FN_CLEAR = 3'd0;
  localparam logic [2:0] FN_ADD   = 3'd1;
  localparam logic [2:0] FN_DEL   = 3'd2;
  localparam logic [2:0] FN_READ  = 3'd3;
  localparam logic [2:0] FN_WRITE = 3'd4;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_PARAM  = 3'd1;
  localparam logic [2:0] ST_LEVEL  = 3'd2;
  localparam logic [2:0] ST_SPACE  = 3'd3;
  localparam logic [2:0] ST_NOPORT = 3'd4;

  localparam logic [1:0] LEVEL_CONFIG = 2'd1;

  typedef enum logic [1:0] {CMD_NONE, CMD_CLEAR, CMD_ADD, CMD_DEL} cmd_op_t;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} fsm_state_t;

  // table update broadcast to every cell
  typedef struct packed {
    cmd_op_t     op;
    logic [11:0] addr;
    logic        src;
    logic [2:0]  code;
  } cmd_t;

  // search token that walks the row of cells
  typedef struct packed {
    logic        active;
    logic [11:0] addr;
    logic        found;
    logic [2:0]  hit_code;
    logic        hit_src;
    logic        free_found;
  } tok_t;

  // {legal, code}: size code of a port byte count
  function automatic logic [3:0] size_code(input logic [5:0] bytes);
    logic [3:0] r;
    case (bytes)
      6'd2:    r = 4'b1000;
      6'd4:    r = 4'b1001;
      6'd8:    r = 4'b1010;
      6'd16:   r = 4'b1011;
      6'd32:   r = 4'b1100;
      default: r = 4'b0000;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/pbta_cell.sv
// One table entry of the port table; passes the search token to its neighbor.
module pbta_cell import pbta_pkg::*; #(
  parameter int IDX_W  = 8,
  parameter int DOCK_W = 10,
  parameter int INDEX  = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tok_t              tok_i,
  input  logic [DOCK_W-1:0] dock_i,
  input  logic [IDX_W-1:0]  fidx_i,
  output tok_t              tok_o,
  output logic [DOCK_W-1:0] dock_o,
  output logic [IDX_W-1:0]  fidx_o,
  input  cmd_t              cmd_i,
  input  logic [IDX_W-1:0]  cmd_slot_i,
  input  logic [DOCK_W-1:0] cmd_dock_i
);

  logic              vld_r;
  logic [11:0]       addr_r;
  logic [DOCK_W-1:0] dock_r;
  logic [2:0]        code_r;
  logic              src_r;

  tok_t              tok_r, tok_nxt;
  logic [DOCK_W-1:0] dock_out_r, dock_out_nxt;
  logic [IDX_W-1:0]  fidx_r, fidx_nxt;

  always_comb begin
    tok_nxt      = tok_i;
    dock_out_nxt = dock_i;
    fidx_nxt     = fidx_i;
    if (tok_i.active) begin
      if (vld_r && addr_r == tok_i.addr && !tok_i.found) begin
        tok_nxt.found    = 1'b1;
        tok_nxt.hit_code = code_r;
        tok_nxt.hit_src  = src_r;
        dock_out_nxt     = dock_r;
      end
      if (!vld_r && !tok_i.free_found) begin
        tok_nxt.free_found = 1'b1;
        fidx_nxt           = IDX_W'(INDEX);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.active <= 1'b0;
    end else begin
      tok_r.active <= tok_nxt.active;
    end
    tok_r.addr       <= tok_nxt.addr;
    tok_r.found      <= tok_nxt.found;
    tok_r.hit_code   <= tok_nxt.hit_code;
    tok_r.hit_src    <= tok_nxt.hit_src;
    tok_r.free_found <= tok_nxt.free_found;
    dock_out_r       <= dock_out_nxt;
    fidx_r           <= fidx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      case (cmd_i.op)
        CMD_CLEAR: vld_r <= 1'b0;
        CMD_ADD:   if (cmd_slot_i == IDX_W'(INDEX)) vld_r <= 1'b1;
        CMD_DEL:   if (vld_r && addr_r == cmd_i.addr) vld_r <= 1'b0;
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.op == CMD_ADD && cmd_slot_i == IDX_W'(INDEX)) begin
      addr_r <= cmd_i.addr;
      dock_r <= cmd_dock_i;
      code_r <= cmd_i.code;
      src_r  <= cmd_i.src;
    end
  end

  assign tok_o  = tok_r;
  assign dock_o = dock_out_r;
  assign fidx_o = fidx_r;

endmodule

>>> rtl/bus_port_table_dock_allocator.sv
// Top level: port table cell row, dock allocator and operation sequencer.
// A transaction is accepted only while idle: the request is registered, the search token
// walks the row of table cells one cell per cycle, the scan result is registered, and the
// response enters the output register once that is free (clear included).
// Reset (synchronous, rst_n low): all table entries unused, next dock 1,
// init level 0, no result pending.
module bus_port_table_dock_allocator import pbta_pkg::*; #(
  parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
  parameter int DOCK_COUNT    = DOCK_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic [11:0] in_logical_address,
  input  logic        in_is_source,
  input  logic [5:0]  in_byte_count,
  input  logic [15:0] in_pcs_word_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [9:0]  out_dock_index,
  output logic [15:0] out_pcs_word0,
  output logic [15:0] out_data_base,
  output logic [15:0] out_pcs_word_out,
  output logic [5:0]  out_length
);

  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int DOCK_W = $clog2(DOCK_COUNT);
  localparam int NFD_W  = DOCK_W + 1;
  localparam int SUM_W  = NFD_W + 1;

  fsm_state_t state_r, state_nxt;

  logic [1:0]  level_r;
  logic [NFD_W-1:0] nfd_r;

  logic [2:0]  req_func_r;
  logic [11:0] req_addr_r;
  logic        req_src_r;
  logic [5:0]  req_bytes_r;
  logic [15:0] req_pcs_r;

  tok_t              scan_r;
  logic [DOCK_W-1:0] hit_dock_r;
  logic [IDX_W-1:0]  free_idx_r;

  tok_t              tok_c  [0:TABLE_ENTRIES];
  logic [DOCK_W-1:0] dock_c [0:TABLE_ENTRIES];
  logic [IDX_W-1:0]  fidx_c [0:TABLE_ENTRIES];

  cmd_t              cmd;
  logic [DOCK_W-1:0] cmd_dock;
  logic              in_acc, finish, scan_end;

  logic        out_valid_r;
  logic [2:0]  st_r;
  logic [9:0]  dock_idx_r;
  logic [15:0] w0_r, base_r, wout_r;
  logic [5:0]  len_r;

  logic [2:0]  st;
  logic [9:0]  dock_idx;
  logic [15:0] w0, base, wout;
  logic [5:0]  len;
  logic [NFD_W-1:0] nfd_nxt;

  assign in_acc   = in_valid && in_ready;
  assign scan_end = tok_c[TABLE_ENTRIES].active;
  assign finish   = (state_r == S_DONE) && (!out_valid_r || out_ready);

  // search token enters the row on accept
  always_comb begin
    tok_c[0]            = '0;
    tok_c[0].active     = in_acc;
    tok_c[0].addr       = in_logical_address;
    dock_c[0]           = '0;
    fidx_c[0]           = '0;
  end

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    pbta_cell #(
      .IDX_W  (IDX_W),
      .DOCK_W (DOCK_W),
      .INDEX  (g)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .tok_i      (tok_c[g]),
      .dock_i     (dock_c[g]),
      .fidx_i     (fidx_c[g]),
      .tok_o      (tok_c[g+1]),
      .dock_o     (dock_c[g+1]),
      .fidx_o     (fidx_c[g+1]),
      .cmd_i      (cmd),
      .cmd_slot_i (free_idx_r),
      .cmd_dock_i (cmd_dock)
    );
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SCAN;
      S_SCAN:  if (scan_end) state_nxt = S_DONE;
      S_DONE:  if (finish) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE:  in_ready = 1'b1;
      S_SCAN:  in_ready = 1'b0;
      S_DONE:  in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  // result and table update, evaluated once the scan is complete
  always_comb begin
    logic [3:0]       sc;
    logic [SUM_W-1:0] docks, idx, top;
    logic             pg;
    logic [31:0]      b;
    logic [5:0]       psize;
    st       = ST_OK;
    dock_idx = '0;
    w0       = '0;
    base     = '0;
    wout     = '0;
    len      = '0;
    cmd      = '0;
    cmd.op   = CMD_NONE;
    cmd.addr = req_addr_r;
    cmd.src  = req_src_r;
    cmd_dock = '0;
    nfd_nxt  = nfd_r;
    sc       = size_code(req_bytes_r);
    cmd.code = sc[2:0];
    docks    = (sc[2:0] == 3'd4) ? SUM_W'(4) : (sc[2:0] == 3'd3) ? SUM_W'(2) : SUM_W'(1);
    idx      = (SUM_W'(nfd_r) + docks - SUM_W'(1)) & ~(docks - SUM_W'(1));
    top      = idx + docks;
    pg       = (req_func_r == FN_WRITE) ? ~req_pcs_r[6] : req_pcs_r[6];
    b        = 32'(DATA_AREA) + (32'(hit_dock_r >> 2) << 6) + (32'(pg) << 5)
             + (32'(hit_dock_r[1:0]) << 3);
    psize    = 6'd2 << scan_r.hit_code;
    case (req_func_r)
      FN_CLEAR: begin
        cmd.op  = CMD_CLEAR;
        nfd_nxt = NFD_W'(1);
      end
      FN_ADD: begin
        if (req_addr_r == 12'd0 || !sc[3]) begin
          st = ST_PARAM;
        end else if (level_r != LEVEL_CONFIG) begin
          st = ST_LEVEL;
        end else if (scan_r.found) begin
          st = ST_PARAM;
        end else if (!scan_r.free_found || top > SUM_W'(DOCK_COUNT)) begin
          st = ST_SPACE;
        end else begin
          cmd.op   = CMD_ADD;
          cmd_dock = DOCK_W'(idx);
          nfd_nxt  = NFD_W'(top);
          dock_idx = 10'(idx);
          w0       = {1'b0, sc[2:0], 12'd0} | (req_src_r ? DIR_SOURCE_BIT : DIR_SINK_BIT);
        end
      end
      FN_DEL: begin
        if (level_r != LEVEL_CONFIG) begin
          st = ST_LEVEL;
        end else if (!scan_r.found) begin
          st = ST_NOPORT;
        end else begin
          cmd.op   = CMD_DEL;
          dock_idx = 10'(hit_dock_r);
        end
      end
      FN_READ, FN_WRITE: begin
        if (req_bytes_r == 6'd0) begin
          st = ST_PARAM;
        end else if (!scan_r.found) begin
          st = ST_NOPORT;
        end else if (req_func_r == FN_WRITE && !scan_r.hit_src) begin
          st = ST_PARAM;
        end else begin
          dock_idx = 10'(hit_dock_r);
          len      = (req_bytes_r > psize) ? psize : req_bytes_r;
          base     = b[15:0];
          if (req_func_r == FN_READ) begin
            wout = req_pcs_r & STATUS_MASK;
          end else begin
            wout = (req_pcs_r & ~VALID_PAGE_BIT) | (pg ? VALID_PAGE_BIT : 16'h0000);
          end
        end
      end
      default: st = ST_PARAM;
    endcase
    if (!finish) begin
      cmd.op  = CMD_NONE;
      nfd_nxt = nfd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      level_r     <= 2'd0;
      nfd_r       <= NFD_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      nfd_r   <= nfd_nxt;
      if (cfg_we) level_r <= cfg_wdata;
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_func_r  <= in_func;
      req_addr_r  <= in_logical_address;
      req_src_r   <= in_is_source;
      req_bytes_r <= in_byte_count;
      req_pcs_r   <= in_pcs_word_in;
    end
    if (scan_end) begin
      scan_r     <= tok_c[TABLE_ENTRIES];
      hit_dock_r <= dock_c[TABLE_ENTRIES];
      free_idx_r <= fidx_c[TABLE_ENTRIES];
    end
    if (finish) begin
      st_r       <= st;
      dock_idx_r <= dock_idx;
      w0_r       <= w0;
      base_r     <= base;
      wout_r     <= wout;
      len_r      <= len;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = st_r;
  assign out_dock_index   = dock_idx_r;
  assign out_pcs_word0    = w0_r;
  assign out_data_base    = base_r;
  assign out_pcs_word_out = wout_r;
  assign out_length       = len_r;

  a_scan_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    scan_end |-> state_r == S_SCAN)
    else $error("search token left the row outside of a scan");

  a_nfd_range: assert property (@(posedge clk) disable iff (!rst_n)
    nfd_r >= NFD_W'(1) && nfd_r <= NFD_W'(DOCK_COUNT))
    else $error("next free dock out of range");

  a_cmd_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op != CMD_NONE |-> finish)
    else $error("table update outside of transaction completion");

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r && state_r == S_IDLE)
    else $error("completed transaction did not reach the output register");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the port table and dock allocator.
module tb_top;
  import pbta_pkg::*;

  localparam int N_ENTRIES = 256;
  localparam int N_DOCKS   = 1024;
  localparam int IDLE_LIMIT = 6000;

  typedef struct packed {
    logic [2:0]  status;
    logic [9:0]  dock_index;
    logic [15:0] pcs_word0;
    logic [15:0] data_base;
    logic [15:0] pcs_word_out;
    logic [5:0]  length;
  } port_resp_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_func;
  logic [11:0] in_logical_address;
  logic        in_is_source;
  logic [5:0]  in_byte_count;
  logic [15:0] in_pcs_word_in;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic [9:0]  out_dock_index;
  logic [15:0] out_pcs_word0;
  logic [15:0] out_data_base;
  logic [15:0] out_pcs_word_out;
  logic [5:0]  out_length;

  bus_port_table_dock_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_logical_address(in_logical_address), .in_is_source(in_is_source),
    .in_byte_count(in_byte_count), .in_pcs_word_in(in_pcs_word_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_dock_index(out_dock_index), .out_pcs_word0(out_pcs_word0),
    .out_data_base(out_data_base), .out_pcs_word_out(out_pcs_word_out),
    .out_length(out_length)
  );

  // shadow of the port table
  logic        port_used [N_ENTRIES];
  logic [11:0] port_addr [N_ENTRIES];
  int          port_dock [N_ENTRIES];
  int          port_size [N_ENTRIES];
  logic        port_src  [N_ENTRIES];
  int          alloc_ptr;
  logic [1:0]  level_shadow;

  port_resp_t resp_q[$];
  int  errors;
  int  idle_cycles;
  bit  no_gaps;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic void table_clear();
    for (int i = 0; i < N_ENTRIES; i++) begin
      port_used[i] = 1'b0;
      port_addr[i] = '0;
      port_dock[i] = 0;
      port_size[i] = 0;
      port_src[i]  = 1'b0;
    end
    alloc_ptr = 1;
  endfunction

  function automatic int lookup_port(logic [11:0] addr);
    for (int i = 0; i < N_ENTRIES; i++)
      if (port_used[i] && port_addr[i] == addr) return i;
    return -1;
  endfunction

  function automatic logic [15:0] page_addr(int dock, int page);
    return 16'(32'h4000 + (dock >> 2) * 64 + page * 32 + (dock & 3) * 8);
  endfunction

  // applies one operation to the shadow table and returns its response
  function automatic port_resp_t table_op(logic [2:0] fn, logic [11:0] addr, logic src,
                                          logic [5:0] bytes, logic [15:0] pcs);
    port_resp_t r;
    int e, slot, docks, idx, code, page;
    r = '0;
    case (fn)
      FN_CLEAR: table_clear();
      FN_ADD: begin
        code = (bytes == 2) ? 0 : (bytes == 4) ? 1 : (bytes == 8) ? 2 :
               (bytes == 16) ? 3 : (bytes == 32) ? 4 : -1;
        slot = -1;
        for (int i = N_ENTRIES - 1; i >= 0; i--) if (!port_used[i]) slot = i;
        if (addr == 0 || code < 0) r.status = ST_PARAM;
        else if (level_shadow != LEVEL_CONFIG) r.status = ST_LEVEL;
        else if (lookup_port(addr) >= 0) r.status = ST_PARAM;
        else if (slot < 0) r.status = ST_SPACE;
        else begin
          docks = (bytes <= 8) ? 1 : bytes / 8;
          idx = alloc_ptr;
          if (docks > 1) idx = (idx + docks - 1) & ~(docks - 1);
          if (idx + docks > N_DOCKS) r.status = ST_SPACE;
          else begin
            alloc_ptr = idx + docks;
            port_used[slot] = 1'b1;
            port_addr[slot] = addr;
            port_dock[slot] = idx;
            port_size[slot] = bytes;
            port_src[slot]  = src;
            r.dock_index = 10'(idx);
            r.pcs_word0 = (16'(code) << 12) | (src ? DIR_SOURCE_BIT : DIR_SINK_BIT);
          end
        end
      end
      FN_DEL: begin
        e = lookup_port(addr);
        if (level_shadow != LEVEL_CONFIG) r.status = ST_LEVEL;
        else if (e < 0) r.status = ST_NOPORT;
        else begin
          r.dock_index = 10'(port_dock[e]);
          port_used[e] = 1'b0;
          port_addr[e] = '0;
        end
      end
      FN_READ, FN_WRITE: begin
        e = lookup_port(addr);
        if (bytes == 0) r.status = ST_PARAM;
        else if (e < 0) r.status = ST_NOPORT;
        else if (fn == FN_WRITE && !port_src[e]) r.status = ST_PARAM;
        else begin
          page = pcs[6];
          r.dock_index = 10'(port_dock[e]);
          r.length = (bytes > port_size[e]) ? 6'(port_size[e]) : bytes;
          if (fn == FN_READ) begin
            r.data_base = page_addr(port_dock[e], page);
            r.pcs_word_out = pcs & STATUS_MASK;
          end else begin
            r.data_base = page_addr(port_dock[e], page ^ 1);
            r.pcs_word_out = (pcs & ~VALID_PAGE_BIT) | (page ? 16'h0 : VALID_PAGE_BIT);
          end
        end
      end
      default: r.status = ST_PARAM;
    endcase
    return r;
  endfunction

  task automatic send_op(logic [2:0] fn, logic [11:0] addr, logic src,
                         logic [5:0] bytes, logic [15:0] pcs);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func <= fn;
    in_logical_address <= addr;
    in_is_source <= src;
    in_byte_count <= bytes;
    in_pcs_word_in <= pcs;
    in_valid <= 1'b1;
    do @(posedge clk); while (!(in_valid && in_ready));
    resp_q.push_back(table_op(fn, addr, src, bytes, pcs));
    @(negedge clk);
  endtask

  // writes the level once the block has drained
  task automatic set_level(logic [1:0] lvl);
    in_valid <= 1'b0;
    while (resp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= lvl;
    @(negedge clk);
    cfg_we <= 1'b0;
    level_shadow = lvl;
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch expected %h actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // response side: random stalls, compare against the oldest expectation
  initial begin
    port_resp_t e;
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = no_gaps ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      if (resp_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction expected none actual status %h",
                 $time, out_status);
      end else begin
        e = resp_q.pop_front();
        check_field("status", e.status, out_status);
        check_field("dock_index", e.dock_index, out_dock_index);
        check_field("pcs_word0", e.pcs_word0, out_pcs_word0);
        check_field("data_base", e.data_base, out_data_base);
        check_field("pcs_word_out", e.pcs_word_out, out_pcs_word_out);
        check_field("length", e.length, out_length);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    set_level(2'd0);
    send_op(FN_CLEAR, 12'd0, 1'b0, 6'd0, 16'h0000);
    send_op(FN_ADD, 12'd5, 1'b1, 6'd8, 16'h0000);      // wrong level
    send_op(FN_DEL, 12'd5, 1'b0, 6'd0, 16'h0000);
    set_level(LEVEL_CONFIG);
    send_op(FN_ADD, 12'd0, 1'b1, 6'd8, 16'h0000);      // address zero
    send_op(FN_ADD, 12'd7, 1'b1, 6'd3, 16'h0000);      // illegal size
    send_op(FN_ADD, 12'd1, 1'b1, 6'd2, 16'h0000);
    send_op(FN_ADD, 12'd2, 1'b0, 6'd4, 16'h0000);
    send_op(FN_ADD, 12'd3, 1'b1, 6'd8, 16'h0000);
    send_op(FN_ADD, 12'd4, 1'b1, 6'd16, 16'h0000);     // aligned to 2
    send_op(FN_ADD, 12'hFFF, 1'b0, 6'd32, 16'h0000);   // aligned to 4
    send_op(FN_ADD, 12'd3, 1'b0, 6'd2, 16'h0000);      // duplicate
    send_op(FN_READ, 12'd4, 1'b0, 6'd63, 16'hFFFF);
    send_op(FN_READ, 12'hFFF, 1'b0, 6'd1, 16'h0000);
    send_op(FN_WRITE, 12'd4, 1'b1, 6'd5, 16'hFFFF);
    send_op(FN_WRITE, 12'd1, 1'b0, 6'd2, 16'h0000);
    send_op(FN_WRITE, 12'd2, 1'b1, 6'd2, 16'h0040);    // sink port
    send_op(FN_READ, 12'd1, 1'b0, 6'd0, 16'h0040);     // zero length
    send_op(FN_READ, 12'd99, 1'b0, 6'd2, 16'h0000);    // unknown port
    send_op(FN_DEL, 12'd3, 1'b0, 6'd0, 16'h0000);
    send_op(FN_DEL, 12'd3, 1'b0, 6'd0, 16'h0000);
    send_op(3'd5, 12'd1, 1'b1, 6'd2, 16'h0000);
    send_op(3'd6, 12'd1, 1'b1, 6'd2, 16'h0000);
    send_op(3'd7, 12'hFFF, 1'b1, 6'h3F, 16'hFFFF);
    set_level(2'd3);
    send_op(FN_DEL, 12'd1, 1'b0, 6'd0, 16'h0000);
    send_op(FN_READ, 12'd1, 1'b0, 6'd2, 16'h0040);
  endtask

  task automatic test_table_full();
    set_level(LEVEL_CONFIG);
    no_gaps = 1'b1;
    send_op(FN_CLEAR, 12'd0, 1'b0, 6'd0, 16'h0000);
    for (int i = 1; i <= N_ENTRIES + 1; i++)
      send_op(FN_ADD, 12'(i), 1'($urandom), 6'd2, 16'(i));
    send_op(FN_DEL, 12'd100, 1'b0, 6'd0, 16'h0000);
    send_op(FN_ADD, 12'd900, 1'b1, 6'd2, 16'h0000);
    no_gaps = 1'b0;
  endtask

  task automatic test_dock_exhaust();
    set_level(LEVEL_CONFIG);
    send_op(FN_CLEAR, 12'd0, 1'b0, 6'd0, 16'h0000);
    send_op(FN_ADD, 12'd1, 1'b1, 6'd2, 16'h0000);
    for (int i = 2; i <= 258; i++) begin
      if (i % 32 == 0) send_op(FN_DEL, 12'(i - 1), 1'b0, 6'd0, 16'h0000);
      send_op(FN_ADD, 12'(i), 1'b1, 6'd32, 16'h0000);
    end
    send_op(FN_ADD, 12'd2000, 1'b0, 6'd16, 16'h0000);
  endtask

  task automatic test_random(int n_items, logic [1:0] lvl);
    logic [2:0]  fn;
    logic [11:0] addr;
    logic [5:0]  bytes;
    int          pick;
    set_level(lvl);
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 5) no_gaps = !no_gaps;
      pick = $urandom_range(0, 99);
      fn = (pick < 2) ? FN_CLEAR : (pick < 35) ? FN_ADD : (pick < 50) ? FN_DEL :
           (pick < 73) ? FN_READ : (pick < 95) ? FN_WRITE : 3'($urandom_range(5, 7));
      pick = $urandom_range(0, 99);
      addr = (pick < 85) ? 12'($urandom_range(1, 48)) : (pick < 92) ? 12'd0 : 12'($urandom);
      if (fn == FN_ADD && $urandom_range(0, 99) < 85) bytes = 6'(2 << $urandom_range(0, 4));
      else bytes = 6'($urandom);
      send_op(fn, addr, 1'($urandom), bytes, 16'($urandom));
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_func = '0;
    in_logical_address = '0;
    in_is_source = 1'b0;
    in_byte_count = '0;
    in_pcs_word_in = '0;
    errors = 0;
    no_gaps = 1'b0;
    level_shadow = 2'd0;
    table_clear();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_table_full();
    test_dock_exhaust();
    test_random(250, LEVEL_CONFIG);
    test_random(100, 2'd0);
    test_random(200, LEVEL_CONFIG);
    test_random(60, 2'd2);
    test_random(100, LEVEL_CONFIG);

    in_valid <= 1'b0;
    while (resp_q.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
